/* design/command_class_list_parser_unit_macros.svh */
// Assertion macros shared by the checker of the command class list parser.
// Depends on nothing; the using scope provides clk and arst_n.
`ifndef COMMAND_CLASS_LIST_PARSER_UNIT_MACROS_SVH
`define COMMAND_CLASS_LIST_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CLPU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clpu assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define CLPU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clpu assertion failed");

`endif

/* design/clpu_pkg.sv */
// Shared types and constants of the command class list parser.
// No dependencies; imported by every module of the block.
package clpu_pkg;

	localparam int BYTE_W             = 8;
	localparam int ID_W               = 16;
	localparam int COUNT_W            = 7;
	localparam int CFG_INDEX_W        = 1;
	localparam int DEF_MAX_LIST_BYTES = 64;
	localparam int DEF_QUEUE_DEPTH    = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	localparam logic [BYTE_W-1:0] MARK_RESET = 8'd239;
	localparam logic [BYTE_W-1:0] EXT_RESET  = 8'd241;

	localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MARK   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTENDED_START = 1'b1;

	localparam logic KIND_ID        = 1'b0;
	localparam logic KIND_SUMMARY   = 1'b1;
	localparam logic TAG_SUPPORTED  = 1'b0;
	localparam logic TAG_CONTROLLED = 1'b1;

	typedef enum logic [2:0] {
		PH_SUPPORTED  = 3'b001,
		PH_CONTROLLED = 3'b010,
		PH_DONE       = 3'b100
	} clpu_phase_t;

	// Work record passed from the front to the back: up to two results.
	typedef struct packed {
		logic               has_id;
		logic [ID_W-1:0]    id;
		logic               tag;
		logic               has_sum;
		logic [COUNT_W-1:0] sup;
		logic [COUNT_W-1:0] ctl;
	} clpu_rec_t;

endpackage

/* design/command_class_list_parser_unit.sv */
// Command class list parser: one frame byte per cycle in while not full, class
// identifiers out. A byte's record passes the queue, then the output register.
// Throughput: one byte per cycle in while not full; one result per cycle out
// while popped, so a byte that ends a frame with an identifier takes two pops.
// Reset (arst_n low, asynchronous): queue and list state clear, the mark register
// returns to 239 and the extended start register to 241. Depends on clpu_pkg.
module command_class_list_parser_unit #(
	parameter int MAX_LIST_BYTES = clpu_pkg::DEF_MAX_LIST_BYTES,
	parameter int QUEUE_DEPTH    = clpu_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte side
	input  logic                              push,
	output logic                              full,
	input  logic [clpu_pkg::BYTE_W-1:0]       frame_byte,
	input  logic                              frame_end,
	// result side
	output logic                              empty,
	input  logic                              pop,
	output logic                              result_kind,
	output logic [clpu_pkg::ID_W-1:0]         class_id,
	output logic                              list_tag,
	output logic [clpu_pkg::COUNT_W-1:0]      supported_total,
	output logic [clpu_pkg::COUNT_W-1:0]      controlled_total,
	output logic                              run_last,
	// configuration writes
	input  logic                              write_en,
	input  logic [clpu_pkg::CFG_INDEX_W-1:0]  reg_index,
	input  logic [clpu_pkg::BYTE_W-1:0]       write_data
);
	import clpu_pkg::*;

	clpu_rec_t front_rec, queue_rec;
	logic      accept, front_valid, queue_empty, queue_pop;

	// A byte transaction completes whenever the queue has room; the front
	// classifies it in the same cycle and drops a record into the queue only
	// when the byte yields an identifier or closes the frame.
	assign accept = push && !full;

	clpu_front #(
		.MAX_LIST_BYTES (MAX_LIST_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.rec_valid  (front_valid),
		.rec        (front_rec)
	);

	// Decouple classification from result delivery so that a stalled
	// consumer does not stop bytes until the queue fills.
	clpu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_rec),
		.rd_en   (queue_pop),
		.rd_data (queue_rec),
		.full    (full),
		.empty   (queue_empty)
	);

	// Hold the current record in the output register and advance through
	// its identifier and summary results as they are popped.
	clpu_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rec              (queue_rec),
		.rec_empty        (queue_empty),
		.rec_pop          (queue_pop),
		.empty            (empty),
		.pop              (pop),
		.result_kind      (result_kind),
		.class_id         (class_id),
		.list_tag         (list_tag),
		.supported_total  (supported_total),
		.controlled_total (controlled_total),
		.run_last         (run_last)
	);

endmodule

/* design/clpu_front.sv */
// Front end: classifies each frame byte, keeps list state and config registers.
// Depends on clpu_pkg.
module clpu_front #(
	parameter int MAX_LIST_BYTES = clpu_pkg::DEF_MAX_LIST_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [clpu_pkg::BYTE_W-1:0]       frame_byte,
	input  logic                              frame_end,
	input  logic                              write_en,
	input  logic [clpu_pkg::CFG_INDEX_W-1:0]  reg_index,
	input  logic [clpu_pkg::BYTE_W-1:0]       write_data,
	output logic                              rec_valid,
	output clpu_pkg::clpu_rec_t               rec
);
	import clpu_pkg::*;

	localparam int BW = $clog2(MAX_LIST_BYTES + 2);

	logic [BYTE_W-1:0]  mark_q, ext_q, held_q, held_n;
	clpu_phase_t        phase_q, phase_n;
	logic               pending_q, pending_n;
	logic [BW-1:0]      nbytes_q, nbytes_n;
	logic [COUNT_W-1:0] sup_q, sup_n, ctl_q, ctl_n;
	logic               take;
	logic [ID_W-1:0]    id;

	always_comb begin
		phase_n   = phase_q;
		held_n    = held_q;
		pending_n = pending_q;
		nbytes_n  = nbytes_q;
		sup_n     = sup_q;
		ctl_n     = ctl_q;
		take      = 1'b0;
		id        = '0;
		if (phase_q != PH_DONE) begin
			if (pending_q) begin
				take      = 1'b1;
				id        = {held_q, frame_byte};
				nbytes_n  = nbytes_q + BW'(1);
				pending_n = 1'b0;
				held_n    = '0;
			end else if (frame_byte == mark_q) begin
				phase_n  = (phase_q == PH_SUPPORTED) ? PH_CONTROLLED : PH_DONE;
				nbytes_n = '0;
			end else if (frame_byte >= ext_q) begin
				// lone extended byte at frame end is dropped
				if (!frame_end) begin
					held_n    = frame_byte;
					pending_n = 1'b1;
					nbytes_n  = nbytes_q + BW'(1);
				end
			end else begin
				take     = 1'b1;
				id       = {{(ID_W-BYTE_W){1'b0}}, frame_byte};
				nbytes_n = nbytes_q + BW'(1);
			end
		end
		if (take) begin
			if (phase_q == PH_SUPPORTED) begin
				if (sup_q != COUNT_MAX) sup_n = sup_q + COUNT_W'(1);
			end else begin
				if (ctl_q != COUNT_MAX) ctl_n = ctl_q + COUNT_W'(1);
			end
			if (nbytes_n >= BW'(MAX_LIST_BYTES)) begin
				phase_n  = (phase_q == PH_SUPPORTED) ? PH_CONTROLLED : PH_DONE;
				nbytes_n = '0;
			end
		end
	end

	assign rec.has_id  = take;
	assign rec.id      = id;
	assign rec.tag     = (phase_q == PH_CONTROLLED) ? TAG_CONTROLLED : TAG_SUPPORTED;
	assign rec.has_sum = frame_end;
	assign rec.sup     = sup_n;
	assign rec.ctl     = ctl_n;
	assign rec_valid   = accept && (take || frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SUPPORTED;
			held_q    <= '0;
			pending_q <= 1'b0;
			nbytes_q  <= '0;
			sup_q     <= '0;
			ctl_q     <= '0;
		end else if (accept) begin
			if (frame_end) begin
				phase_q   <= PH_SUPPORTED;
				held_q    <= '0;
				pending_q <= 1'b0;
				nbytes_q  <= '0;
				sup_q     <= '0;
				ctl_q     <= '0;
			end else begin
				phase_q   <= phase_n;
				held_q    <= held_n;
				pending_q <= pending_n;
				nbytes_q  <= nbytes_n;
				sup_q     <= sup_n;
				ctl_q     <= ctl_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= MARK_RESET;
			ext_q  <= EXT_RESET;
		end else if (write_en) begin
			case (reg_index)
				REG_CONTROL_MARK:   mark_q <= write_data;
				REG_EXTENDED_START: ext_q  <= write_data;
				default:            ;
			endcase
		end
	end

endmodule

/* design/clpu_fifo.sv */
// Short queue of work records between the front end and the result sequencer.
// Depends on clpu_pkg.
module clpu_fifo #(
	parameter int DEPTH = clpu_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  clpu_pkg::clpu_rec_t  wr_data,
	input  logic                 rd_en,
	output clpu_pkg::clpu_rec_t  rd_data,
	output logic                 full,
	output logic                 empty
);
	import clpu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	clpu_rec_t     mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (do_rd) rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (do_wr && !do_rd)      count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

endmodule

/* design/clpu_back.sv */
// Result sequencer: unpacks each work record into one or two results.
// Depends on clpu_pkg.
module clpu_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  clpu_pkg::clpu_rec_t            rec,
	input  logic                           rec_empty,
	output logic                           rec_pop,
	output logic                           empty,
	input  logic                           pop,
	output logic                           result_kind,
	output logic [clpu_pkg::ID_W-1:0]      class_id,
	output logic                           list_tag,
	output logic [clpu_pkg::COUNT_W-1:0]   supported_total,
	output logic [clpu_pkg::COUNT_W-1:0]   controlled_total,
	output logic                           run_last
);
	import clpu_pkg::*;

	clpu_rec_t cur_q;
	logic      valid_q, sum_q;
	logic      show_id, taken, finish;

	// Show the identifier first, then the summary of the same byte.
	assign show_id = cur_q.has_id && !sum_q;
	assign taken   = valid_q && pop;
	assign finish  = taken && !(show_id && cur_q.has_sum);
	assign rec_pop = (!valid_q || finish) && !rec_empty;

	assign empty            = !valid_q;
	assign result_kind      = show_id ? KIND_ID : KIND_SUMMARY;
	assign class_id         = show_id ? cur_q.id : '0;
	assign list_tag         = show_id ? cur_q.tag : TAG_SUPPORTED;
	assign supported_total  = show_id ? '0 : cur_q.sup;
	assign controlled_total = show_id ? '0 : cur_q.ctl;
	assign run_last         = show_id ? !cur_q.has_sum : 1'b1;

	always_ff @(posedge clk) begin
		if (rec_pop) cur_q <= rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sum_q   <= 1'b0;
		end else if (rec_pop) begin
			valid_q <= 1'b1;
			sum_q   <= 1'b0;
		end else if (finish) begin
			valid_q <= 1'b0;
			sum_q   <= 1'b0;
		end else if (taken) begin
			sum_q <= 1'b1;
		end
	end

endmodule

/* design/clpu_checker.sv */
// Port-level checker of the command class list parser, bound to the top level.
// Depends on clpu_pkg and command_class_list_parser_unit_macros.svh.
`include "command_class_list_parser_unit_macros.svh"

module clpu_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              empty,
	input logic                              pop,
	input logic                              result_kind,
	input logic [clpu_pkg::ID_W-1:0]         class_id,
	input logic                              list_tag,
	input logic [clpu_pkg::COUNT_W-1:0]      supported_total,
	input logic [clpu_pkg::COUNT_W-1:0]      controlled_total,
	input logic                              run_last
);
	import clpu_pkg::*;

	// A summary closes its byte's run and carries no identifier.
	`CLPU_ASSERT_NOW(a_summary_clean, !empty && result_kind == KIND_SUMMARY, class_id == '0 && list_tag == TAG_SUPPORTED && run_last)
	// An identifier result carries no totals.
	`CLPU_ASSERT_NOW(a_id_no_totals, !empty && result_kind == KIND_ID, supported_total == '0 && controlled_total == '0)
	// An identifier that is not last in its run is followed by its summary.
	`CLPU_ASSERT_NEXT(a_id_then_summary, !empty && pop && result_kind == KIND_ID && !run_last, !empty && result_kind == KIND_SUMMARY)
	// A waiting result holds while not popped.
	`CLPU_ASSERT_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(class_id) && $stable(result_kind) && $stable(run_last))

endmodule

bind command_class_list_parser_unit clpu_checker u_clpu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.empty            (empty),
	.pop              (pop),
	.result_kind      (result_kind),
	.class_id         (class_id),
	.list_tag         (list_tag),
	.supported_total  (supported_total),
	.controlled_total (controlled_total),
	.run_last         (run_last)
);
